// ===== rtl/b62nc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b62nc_pkg
// Shared types, constants and helpers for the base-62 number codec.
// ----------------------------------------------------------------------------
package b62nc_pkg;

  localparam int MAX_DIGITS_DEF = 11;

  localparam int NUM_IN_W  = 63;
  localparam int NUM_OUT_W = 64;
  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 6;

  // long division by 62 runs over the 64-bit work word in 16-bit chunks
  localparam int WORK_W   = 64;
  localparam int CHUNK_W  = 16;
  localparam int CHUNKS   = WORK_W / CHUNK_W;
  localparam int CHUNK_IW = $clog2(CHUNKS);
  localparam int DIVX_W   = DIGIT_W + CHUNK_W;

  // floor(x / 62) == (x * RECIP_MUL) >> RECIP_SHIFT for every x < 62 * 2^16
  localparam int RECIP_MUL_W = 23;
  localparam logic [RECIP_MUL_W-1:0] RECIP_MUL = 23'd4329605;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_PROD_W = DIVX_W + RECIP_MUL_W;

  // accumulator times 62 fits in 70 bits, plus a digit in 71
  localparam int MUL62_W = NUM_OUT_W + 6;
  localparam int SUM_W   = MUL62_W + 1;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_NUM  = 1'b1;

  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'd65;
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] DIGIT_UPPER   = 8'd26;
  localparam logic [CHAR_W-1:0] DIGIT_NUMERIC = 8'd52;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC_CHECK,
    ST_ENC_DIV,
    ST_ENC_EMPTY,
    ST_ENC_SEND,
    ST_DEC_MUL,
    ST_DEC_ADD,
    ST_DEC_SEND
  } b62nc_state_t;

  typedef struct packed {
    logic                 kind;
    logic [CHAR_W-1:0]    char_out;
    logic [NUM_OUT_W-1:0] number_out;
    logic                 overflow;
    logic                 empty_res;
    logic                 last_out;
  } b62nc_out_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = {2'b00, d};
    if (dw < DIGIT_UPPER) begin
      return ASCII_LOWER_A + dw;
    end else if (dw < DIGIT_NUMERIC) begin
      return ASCII_UPPER_A + (dw - DIGIT_UPPER);
    end else begin
      return ASCII_ZERO + (dw - DIGIT_NUMERIC);
    end
  endfunction

  // any byte maps to a digit value, which may exceed 61
  function automatic logic [CHAR_W-1:0] ascii_to_digit(input logic [CHAR_W-1:0] x);
    if (x >= ASCII_LOWER_A) begin
      return x - ASCII_LOWER_A;
    end else if (x >= ASCII_UPPER_A) begin
      return x - (ASCII_UPPER_A - DIGIT_UPPER);
    end else begin
      return x + (DIGIT_NUMERIC - ASCII_ZERO);
    end
  endfunction

endpackage

// ===== rtl/b62nc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b62nc_if
// Valid/ready channels of the base-62 number codec: request and result.
// ----------------------------------------------------------------------------
interface b62nc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [b62nc_pkg::NUM_IN_W-1:0]      number_in;
  logic [b62nc_pkg::CHAR_W-1:0]        char_in;
  logic                                last_char;

  modport source (output valid, func, number_in, char_in, last_char, input ready);
  modport sink   (input valid, func, number_in, char_in, last_char, output ready);
endinterface

interface b62nc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [b62nc_pkg::CHAR_W-1:0]        char_out;
  logic [b62nc_pkg::NUM_OUT_W-1:0]     number_out;
  logic                                overflow;
  logic                                empty_res;
  logic                                last_out;

  modport source (output valid, kind, char_out, number_out, overflow, empty_res, last_out,
                  input ready);
  modport sink   (input valid, kind, char_out, number_out, overflow, empty_res, last_out,
                  output ready);
endinterface

// ===== rtl/base62_number_codec_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base62_number_codec_unit
// Encodes numbers to base-62 text and decodes text one character at a time.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  ---------+-----+-------------------------------------------------------
//  in_bus   | in  | func, number_in, char_in, last_char
//  out_bus  | out | kind, char_out, number_out, overflow, empty_res, last_out
//
//  encode: each base-62 digit takes a check step and the chunk steps of the shared divide-by-62
//  unit, one per 16-bit chunk; then one character is emitted per cycle while out_bus is not stalled
//  decode: each character takes a multiply and an add step, the last one also a send step
//  in_bus.ready is high only in the idle state: between encodes, and between the characters of a decode
//  results sit in an output register; a stalled out_bus holds the sequencer in its send states
//  synchronous active-low reset clears the sequencer, output valid,
//  digit count, chunk counter, read index, accumulator and overflow flag
// ----------------------------------------------------------------------------
module base62_number_codec_unit #(
  parameter int MAX_DIGITS = b62nc_pkg::MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  b62nc_in_if.sink           in_bus,
  b62nc_out_if.source        out_bus
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  b62nc_pkg::b62nc_state_t state_r, state_nxt;

  logic [b62nc_pkg::WORK_W-1:0]     work_r, work_nxt;
  logic [b62nc_pkg::DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [b62nc_pkg::CHUNK_IW-1:0]   chunk_r, chunk_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [IDX_W-1:0]                 idx_r, idx_nxt;
  logic [b62nc_pkg::DIGIT_W-1:0]    rd_r;

  logic [b62nc_pkg::NUM_OUT_W-1:0]  acc_r, acc_nxt;
  logic                             ovf_r, ovf_nxt;
  logic [b62nc_pkg::MUL62_W-1:0]    prod_r, prod_nxt;
  logic [b62nc_pkg::CHAR_W-1:0]     dig_r, dig_nxt;
  logic                             last_r, last_nxt;

  logic                             out_valid_r, out_valid_nxt;
  b62nc_pkg::b62nc_out_t            out_r, out_nxt;

  logic [b62nc_pkg::DIGIT_W-1:0]    mem [MAX_DIGITS];
  logic                             mem_we;

  logic                             in_acc;
  logic                             slot_free;
  logic                             div_done;
  logic                             enc_stop;

  // divide-by-62 chunk step
  logic [b62nc_pkg::DIVX_W-1:0]       div_x;
  logic [b62nc_pkg::RECIP_PROD_W-1:0] div_prod;
  logic [b62nc_pkg::CHUNK_W-1:0]      div_q;
  logic [b62nc_pkg::DIVX_W-1:0]       div_q62;
  logic [b62nc_pkg::DIVX_W-1:0]       div_r;

  logic [b62nc_pkg::MUL62_W-1:0]      mul62;
  logic [b62nc_pkg::SUM_W-1:0]        dec_sum;

  assign in_bus.ready = (state_r == b62nc_pkg::ST_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign slot_free    = !out_valid_r || out_bus.ready;

  assign div_x    = {rem_r, work_r[b62nc_pkg::WORK_W-1 -: b62nc_pkg::CHUNK_W]};
  assign div_prod = {{b62nc_pkg::RECIP_MUL_W{1'b0}}, div_x}
                  * {{b62nc_pkg::DIVX_W{1'b0}}, b62nc_pkg::RECIP_MUL};
  assign div_q    = div_prod[b62nc_pkg::RECIP_SHIFT +: b62nc_pkg::CHUNK_W];
  assign div_q62  = {div_q, 6'b0} - {5'b0, div_q, 1'b0};
  assign div_r    = div_x - div_q62;
  assign div_done = (chunk_r == b62nc_pkg::CHUNK_IW'(b62nc_pkg::CHUNKS - 1));
  assign enc_stop = (work_r == '0) || (cnt_r == CNT_W'(MAX_DIGITS));

  assign mul62   = {acc_r, 6'b0} - {5'b0, acc_r, 1'b0};
  assign dec_sum = {1'b0, prod_r} + b62nc_pkg::SUM_W'(dig_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      b62nc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_bus.func == b62nc_pkg::FUNC_ENCODE) ?
                      b62nc_pkg::ST_ENC_CHECK : b62nc_pkg::ST_DEC_MUL;
        end
      end
      b62nc_pkg::ST_ENC_CHECK: begin
        if (enc_stop) begin
          state_nxt = (cnt_r == '0) ? b62nc_pkg::ST_ENC_EMPTY : b62nc_pkg::ST_ENC_SEND;
        end else begin
          state_nxt = b62nc_pkg::ST_ENC_DIV;
        end
      end
      b62nc_pkg::ST_ENC_DIV: begin
        if (div_done) begin
          state_nxt = b62nc_pkg::ST_ENC_CHECK;
        end
      end
      b62nc_pkg::ST_ENC_EMPTY: begin
        if (slot_free) begin
          state_nxt = b62nc_pkg::ST_IDLE;
        end
      end
      b62nc_pkg::ST_ENC_SEND: begin
        if (slot_free && idx_r == '0) begin
          state_nxt = b62nc_pkg::ST_IDLE;
        end
      end
      b62nc_pkg::ST_DEC_MUL: begin
        state_nxt = b62nc_pkg::ST_DEC_ADD;
      end
      b62nc_pkg::ST_DEC_ADD: begin
        state_nxt = last_r ? b62nc_pkg::ST_DEC_SEND : b62nc_pkg::ST_IDLE;
      end
      b62nc_pkg::ST_DEC_SEND: begin
        if (slot_free) begin
          state_nxt = b62nc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = b62nc_pkg::ST_IDLE;
    endcase
  end

  // datapath and output word
  always_comb begin
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    chunk_nxt     = chunk_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    prod_nxt      = prod_r;
    dig_nxt       = dig_r;
    last_nxt      = last_r;
    mem_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_nxt       = out_r;
    case (state_r)
      b62nc_pkg::ST_IDLE: begin
        if (in_acc) begin
          work_nxt = {1'b0, in_bus.number_in};
          cnt_nxt  = '0;
          dig_nxt  = b62nc_pkg::ascii_to_digit(in_bus.char_in);
          last_nxt = in_bus.last_char;
        end
      end
      b62nc_pkg::ST_ENC_CHECK: begin
        rem_nxt   = '0;
        chunk_nxt = '0;
        idx_nxt   = IDX_W'(cnt_r - CNT_W'(1));
      end
      b62nc_pkg::ST_ENC_DIV: begin
        // quotient chunks shift in as dividend chunks shift out
        work_nxt  = {work_r[b62nc_pkg::WORK_W-b62nc_pkg::CHUNK_W-1:0], div_q};
        rem_nxt   = div_r[b62nc_pkg::DIGIT_W-1:0];
        chunk_nxt = chunk_r + b62nc_pkg::CHUNK_IW'(1);
        if (div_done) begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      b62nc_pkg::ST_ENC_EMPTY: begin
        if (slot_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.kind       = b62nc_pkg::KIND_CHAR;
          out_nxt.char_out   = '0;
          out_nxt.number_out = '0;
          out_nxt.overflow   = 1'b0;
          out_nxt.empty_res  = 1'b1;
          out_nxt.last_out   = 1'b1;
        end
      end
      b62nc_pkg::ST_ENC_SEND: begin
        if (slot_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.kind       = b62nc_pkg::KIND_CHAR;
          out_nxt.char_out   = b62nc_pkg::digit_to_ascii(rd_r);
          out_nxt.number_out = '0;
          out_nxt.overflow   = 1'b0;
          out_nxt.empty_res  = 1'b0;
          out_nxt.last_out   = (idx_r == '0);
          if (idx_r != '0) begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      b62nc_pkg::ST_DEC_MUL: begin
        prod_nxt = mul62;
      end
      b62nc_pkg::ST_DEC_ADD: begin
        acc_nxt = dec_sum[b62nc_pkg::NUM_OUT_W-1:0];
        ovf_nxt = ovf_r || (dec_sum[b62nc_pkg::SUM_W-1:b62nc_pkg::NUM_OUT_W] != '0);
      end
      b62nc_pkg::ST_DEC_SEND: begin
        if (slot_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.kind       = b62nc_pkg::KIND_NUM;
          out_nxt.char_out   = '0;
          out_nxt.number_out = acc_r;
          out_nxt.overflow   = ovf_r;
          out_nxt.empty_res  = 1'b0;
          out_nxt.last_out   = 1'b1;
          acc_nxt            = '0;
          ovf_nxt            = 1'b0;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= b62nc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      chunk_r     <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      chunk_r     <= chunk_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    prod_r <= prod_nxt;
    dig_r  <= dig_nxt;
    last_r <= last_nxt;
    out_r  <= out_nxt;
  end

  // digit buffer, least significant digit at entry 0
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IDX_W-1:0]] <= div_r[b62nc_pkg::DIGIT_W-1:0];
    end
    rd_r <= mem[idx_nxt];
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.kind       = out_r.kind;
  assign out_bus.char_out   = out_r.char_out;
  assign out_bus.number_out = out_r.number_out;
  assign out_bus.overflow   = out_r.overflow;
  assign out_bus.empty_res  = out_r.empty_res;
  assign out_bus.last_out   = out_r.last_out;

endmodule
